// ===== design/hte_pkg.sv =====
package hte_pkg;

    // default limits and fixed store depths
    localparam int TAG_LIMIT_DEF    = 63;
    localparam int ENTITY_LIMIT_DEF = 15;
    localparam int TAG_DEPTH        = 12;
    localparam int ENT_DEPTH        = 5;
    localparam int QUEUE_DEPTH      = 2;
    localparam int WORD_MAX         = 11;
    localparam int BLOCK_COUNT      = 27;

    localparam logic [7:0] CODE_LIMIT = 8'd128;

    // character codes
    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_AMP   = 8'h26;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_X     = 8'h78;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_QUOT  = 8'h22;
    localparam logic [7:0] CH_APOS  = 8'h27;

    // one classified input word, front to back
    typedef struct packed {
        logic [7:0] raw;
        logic [7:0] low;
        logic       eod;
        logic       is_ws;
        logic       is_lt;
        logic       is_gt;
        logic       is_amp;
        logic       is_semi;
        logic       is_x;
        logic       dec_ok;
        logic       hex_ok;
        logic [3:0] nib;
    } item_t;

    typedef logic [TAG_DEPTH-1:0][7:0] name_buf_t;
    typedef logic [TAG_DEPTH:0]        len_vec_t;

    // a name to match; text holds the string with its last char in byte 0
    typedef struct packed {
        logic [3:0]                wlen;
        logic [WORD_MAX-1:0][7:0] text;
    } word_t;

    localparam word_t W_SCRIPT   = '{4'd6, 88'("script")};
    localparam word_t W_STYLE    = '{4'd5, 88'("style")};
    localparam word_t W_CSCRIPT  = '{4'd7, 88'("/script")};
    localparam word_t W_CSTYLE   = '{4'd6, 88'("/style")};
    localparam word_t W_AMP      = '{4'd3, 88'("amp")};
    localparam word_t W_LT       = '{4'd2, 88'("lt")};
    localparam word_t W_GT       = '{4'd2, 88'("gt")};
    localparam word_t W_QUOT     = '{4'd4, 88'("quot")};
    localparam word_t W_APOS     = '{4'd4, 88'("apos")};

    localparam word_t BLOCK_WORDS [0:BLOCK_COUNT-1] = '{
        '{4'd1,  88'("p")},   '{4'd3, 88'("div")}, '{4'd2, 88'("br")},
        '{4'd2,  88'("li")},  '{4'd2, 88'("tr")},  '{4'd2, 88'("dt")},
        '{4'd2,  88'("dd")},  '{4'd10, 88'("blockquote")},
        '{4'd2,  88'("h1")},  '{4'd2, 88'("h2")},  '{4'd2, 88'("h3")},
        '{4'd2,  88'("h4")},  '{4'd2, 88'("h5")},  '{4'd2, 88'("h6")},
        '{4'd2,  88'("/p")},  '{4'd4, 88'("/div")}, '{4'd3, 88'("/li")},
        '{4'd3,  88'("/tr")}, '{4'd3, 88'("/dt")}, '{4'd3, 88'("/dd")},
        '{4'd11, 88'("/blockquote")},
        '{4'd3,  88'("/h1")}, '{4'd3, 88'("/h2")}, '{4'd3, 88'("/h3")},
        '{4'd3,  88'("/h4")}, '{4'd3, 88'("/h5")}, '{4'd3, 88'("/h6")}
    };

    function automatic logic is_ws(input logic [7:0] c);
        return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
    endfunction

    function automatic logic name_end(input logic [7:0] c);
        return (c == CH_SPACE) || (c == CH_SLASH) || (c == CH_TAB) || (c == CH_NL);
    endfunction

    // buffer bytes are stored lowercase; len_eq[k] = (len == k), len_ge[k] = (len >= k)
    function automatic logic word_hit(input name_buf_t b, input int depth,
                                      input len_vec_t len_eq, input len_vec_t len_ge,
                                      input word_t w);
        logic hit;
        int   wl;
        wl  = int'(w.wlen);
        hit = len_ge[w.wlen] && (wl <= depth);
        for (int i = 0; i < WORD_MAX; i++) begin
            if (i < wl) begin
                if (b[i] != w.text[wl-1-i]) hit = 1'b0;
            end
        end
        if (hit && !len_eq[w.wlen]) hit = (wl < depth) && name_end(b[wl]);
        return hit;
    endfunction

endpackage

// ===== design/hte_front.sv =====
module hte_front (
    input  logic           s_tvalid,
    output logic           s_tready,
    input  logic [7:0]     s_tdata,   // [7:0] data_byte
    input  logic           s_tlast,   // end_of_document
    input  logic           q_full,
    output logic           push,
    output hte_pkg::item_t item
);
    import hte_pkg::*;

    logic [7:0] low;

    // handshake: take a word whenever the queue has room
    assign s_tready = !q_full;
    assign push     = s_tvalid && !q_full;

    // fold A-Z to lowercase
    assign low = (s_tdata >= 8'h41 && s_tdata <= 8'h5A) ? (s_tdata | 8'h20) : s_tdata;

    // per-byte classification
    always_comb begin
        item.raw     = s_tdata;
        item.low     = low;
        item.eod     = s_tlast;
        item.is_ws   = is_ws(s_tdata);
        item.is_lt   = (s_tdata == CH_LT);
        item.is_gt   = (s_tdata == CH_GT);
        item.is_amp  = (s_tdata == CH_AMP);
        item.is_semi = (s_tdata == CH_SEMI);
        item.is_x    = (low == CH_X);
        item.dec_ok  = (s_tdata >= 8'h30 && s_tdata <= 8'h39);
        item.hex_ok  = (low >= 8'h61 && low <= 8'h66);
        item.nib     = item.dec_ok ? s_tdata[3:0] : 4'(s_tdata[2:0] + 3'd1) + 4'd8;
    end

endmodule

// ===== design/hte_queue.sv =====
module hte_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  hte_pkg::item_t wr_item,
    output logic           full,
    input  logic           pop,
    output logic           valid,
    output hte_pkg::item_t rd_item
);
    import hte_pkg::*;

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    item_t          mem_reg [QUEUE_DEPTH];
    logic [PW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]  count_reg, count_next;
    logic           do_push, do_pop;

    assign full    = (count_reg == CW'(QUEUE_DEPTH));
    assign valid   = (count_reg != '0);
    assign rd_item = mem_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && valid;

    // pointer and fill count update
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) count_next = count_reg + 1'b1;
        else if (!do_push && do_pop) count_next = count_reg - 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge aclk) begin
        if (do_push) mem_reg[wr_ptr_reg] <= wr_item;
    end

endmodule

// ===== design/hte_back.sv =====
module hte_back #(
    parameter int TAG_LIMIT    = hte_pkg::TAG_LIMIT_DEF,
    parameter int ENTITY_LIMIT = hte_pkg::ENTITY_LIMIT_DEF
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           item_valid,
    input  hte_pkg::item_t item,
    output logic           item_pop,
    output logic           m_tvalid,
    input  logic           m_tready,
    output logic [7:0]     m_tdata,   // [7:0] text_byte
    output logic           m_tlast    // document_end
);
    import hte_pkg::*;

    localparam int TW = $clog2(TAG_LIMIT + 1);
    localparam int EW = $clog2(ENTITY_LIMIT + 1);

    // parser state
    logic                        in_tag_reg, in_tag_next;
    logic                        skip_reg, skip_next;
    logic                        in_ent_reg, in_ent_next;
    logic                        lws_reg, lws_next;
    logic                        stop_reg, stop_next;
    logic [TW-1:0]               tag_len_reg, tag_len_next;
    logic [EW-1:0]               ent_len_reg, ent_len_next;
    logic [7:0]                  num_reg, num_next;
    name_buf_t                   tag_buf_reg;
    logic [ENT_DEPTH-1:0][7:0]   ent_buf_reg;
    logic                        tag_wr, ent_wr;

    // output register
    logic       out_valid_reg, out_valid_next;
    logic [7:0] out_byte_reg, out_byte_next;
    logic       out_last_reg, out_last_next;

    logic       can_take, fire;
    logic       emit, emit_last;
    logic [7:0] emit_byte;
    logic       txt_req;
    logic [7:0] txt_char;

    len_vec_t   tag_eq, tag_ge, ent_eq, ent_ge;
    name_buf_t  ent_view;
    logic [7:0] pos8;
    logic       hex_sel, take, digit_ok;
    logic [11:0] prod, acc;
    logic [7:0] sat;
    logic [7:0] dec_char;
    logic       open_hit, close_hit, skip_after, block_hit;

    assign can_take = !out_valid_reg || m_tready;
    assign item_pop = item_valid && can_take;
    assign fire     = item_pop;

    // length decode for name matching
    always_comb begin
        for (int k = 0; k <= TAG_DEPTH; k++) begin
            tag_eq[k] = (8'(tag_len_reg) == 8'(k));
            tag_ge[k] = (8'(tag_len_reg) >= 8'(k));
            ent_eq[k] = (8'(ent_len_reg) == 8'(k));
            ent_ge[k] = (8'(ent_len_reg) >= 8'(k));
        end
        ent_view = '0;
        for (int i = 0; i < ENT_DEPTH; i++) ent_view[i] = ent_buf_reg[i];
    end

    // numeric entity digit accumulation, saturating at 255
    assign pos8     = 8'(ent_len_reg);
    assign hex_sel  = (pos8 == 8'd1) ? item.is_x : (ent_buf_reg[1] == CH_X);
    assign take     = (pos8 != 8'd0) && (ent_buf_reg[0] == CH_HASH) && !stop_reg
                      && !(hex_sel && pos8 == 8'd1);
    assign digit_ok = item.dec_ok || (hex_sel && item.hex_ok);
    assign prod     = hex_sel ? {num_reg, 4'b0000}
                              : ({1'b0, num_reg, 3'b000} + {3'b000, num_reg, 1'b0});
    assign acc      = prod + {8'h00, item.nib};
    assign sat      = (acc > 12'd255) ? 8'hFF : acc[7:0];

    // entity decode
    always_comb begin
        if (ent_len_reg == '0) dec_char = CH_SPACE;
        else if (ent_buf_reg[0] == CH_HASH)
            dec_char = (num_reg != 8'd0 && num_reg < CODE_LIMIT) ? num_reg : CH_SPACE;
        else if (word_hit(ent_view, ENT_DEPTH, ent_eq, ent_ge, W_AMP))  dec_char = CH_AMP;
        else if (word_hit(ent_view, ENT_DEPTH, ent_eq, ent_ge, W_LT))   dec_char = CH_LT;
        else if (word_hit(ent_view, ENT_DEPTH, ent_eq, ent_ge, W_GT))   dec_char = CH_GT;
        else if (word_hit(ent_view, ENT_DEPTH, ent_eq, ent_ge, W_QUOT)) dec_char = CH_QUOT;
        else if (word_hit(ent_view, ENT_DEPTH, ent_eq, ent_ge, W_APOS)) dec_char = CH_APOS;
        else dec_char = CH_SPACE;
    end

    // tag name classification at '>'
    always_comb begin
        open_hit  = word_hit(tag_buf_reg, TAG_DEPTH, tag_eq, tag_ge, W_SCRIPT)
                 || word_hit(tag_buf_reg, TAG_DEPTH, tag_eq, tag_ge, W_STYLE);
        close_hit = word_hit(tag_buf_reg, TAG_DEPTH, tag_eq, tag_ge, W_CSCRIPT)
                 || word_hit(tag_buf_reg, TAG_DEPTH, tag_eq, tag_ge, W_CSTYLE);
        skip_after = open_hit ? 1'b1 : (close_hit ? 1'b0 : skip_reg);
        block_hit = 1'b0;
        for (int k = 0; k < BLOCK_COUNT; k++) begin
            if (word_hit(tag_buf_reg, TAG_DEPTH, tag_eq, tag_ge, BLOCK_WORDS[k]))
                block_hit = 1'b1;
        end
    end

    // main parser step
    always_comb begin
        in_tag_next  = in_tag_reg;
        skip_next    = skip_reg;
        in_ent_next  = in_ent_reg;
        lws_next     = lws_reg;
        stop_next    = stop_reg;
        tag_len_next = tag_len_reg;
        ent_len_next = ent_len_reg;
        num_next     = num_reg;
        tag_wr       = 1'b0;
        ent_wr       = 1'b0;
        emit         = 1'b0;
        emit_byte    = CH_NL;
        emit_last    = 1'b0;
        txt_req      = 1'b0;
        txt_char     = item.raw;

        if (item.eod) begin
            in_tag_next  = 1'b0;
            skip_next    = 1'b0;
            in_ent_next  = 1'b0;
            lws_next     = 1'b1;
            stop_next    = 1'b0;
            tag_len_next = '0;
            ent_len_next = '0;
            num_next     = '0;
            emit         = 1'b1;
            emit_last    = 1'b1;
        end else if (in_ent_reg) begin
            if (item.is_semi || 8'(ent_len_reg) >= 8'(ENTITY_LIMIT)) begin
                in_ent_next = 1'b0;
                if (!skip_reg && !in_tag_reg) begin
                    txt_req  = 1'b1;
                    txt_char = dec_char;
                end
            end else begin
                ent_wr = (8'(ent_len_reg) < 8'(ENT_DEPTH));
                if (take) begin
                    if (digit_ok) num_next = sat;
                    else stop_next = 1'b1;
                end
                ent_len_next = ent_len_reg + 1'b1;
            end
        end else if (item.is_amp && !in_tag_reg) begin
            in_ent_next  = 1'b1;
            ent_len_next = '0;
            num_next     = '0;
            stop_next    = 1'b0;
        end else if (item.is_lt) begin
            in_tag_next  = 1'b1;
            tag_len_next = '0;
        end else if (in_tag_reg) begin
            if (item.is_gt) begin
                in_tag_next = 1'b0;
                skip_next   = skip_after;
                if (!skip_after && block_hit) begin
                    lws_next  = 1'b1;
                    emit      = 1'b1;
                    emit_byte = CH_NL;
                end
            end else if (8'(tag_len_reg) < 8'(TAG_LIMIT)) begin
                tag_wr       = (8'(tag_len_reg) < 8'(TAG_DEPTH));
                tag_len_next = tag_len_reg + 1'b1;
            end
        end else if (!skip_reg) begin
            txt_req = 1'b1;
        end

        // whitespace collapsing on text output
        if (txt_req) begin
            if (is_ws(txt_char)) begin
                if (!lws_reg) begin
                    lws_next  = 1'b1;
                    emit      = 1'b1;
                    emit_byte = CH_SPACE;
                end
            end else begin
                lws_next  = 1'b0;
                emit      = 1'b1;
                emit_byte = txt_char;
            end
        end
    end

    // output register load
    always_comb begin
        out_valid_next = out_valid_reg && !m_tready;
        out_byte_next  = out_byte_reg;
        out_last_next  = out_last_reg;
        if (fire) begin
            out_valid_next = emit;
            if (emit) begin
                out_byte_next = emit_byte;
                out_last_next = emit_last;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_tag_reg    <= 1'b0;
            skip_reg      <= 1'b0;
            in_ent_reg    <= 1'b0;
            lws_reg       <= 1'b1;
            stop_reg      <= 1'b0;
            tag_len_reg   <= '0;
            ent_len_reg   <= '0;
            num_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
            if (fire) begin
                in_tag_reg  <= in_tag_next;
                skip_reg    <= skip_next;
                in_ent_reg  <= in_ent_next;
                lws_reg     <= lws_next;
                stop_reg    <= stop_next;
                tag_len_reg <= tag_len_next;
                ent_len_reg <= ent_len_next;
                num_reg     <= num_next;
            end
        end
    end

    // name prefix stores and output payload
    always_ff @(posedge aclk) begin
        out_byte_reg <= out_byte_next;
        out_last_reg <= out_last_next;
        for (int i = 0; i < TAG_DEPTH; i++) begin
            if (fire && tag_wr && 8'(tag_len_reg) == 8'(i)) tag_buf_reg[i] <= item.low;
        end
        for (int i = 0; i < ENT_DEPTH; i++) begin
            if (fire && ent_wr && 8'(ent_len_reg) == 8'(i)) ent_buf_reg[i] <= item.low;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_byte_reg;
    assign m_tlast  = out_last_reg;

endmodule

// ===== design/html_text_extractor_core.sv =====
// Channel  | Dir | tdata                | tlast           | Notes
// s_       | in  | [7:0] data_byte      | end_of_document | one document byte per word
// m_       | out | [7:0] text_byte      | document_end    | zero or one word per input word
//
// One input word per cycle sustained while m_ does not stall. A taken input word is
// classified into the 2-entry queue; the parser step then loads its result into the
// output register.
// aresetn is synchronous, active low; it returns the parser to the start of a
// document. An end-of-document word does the same after emitting the final newline.
// A stall on m_ with a result waiting holds the parser; the queue keeps s_ open for
// up to two more words.
module html_text_extractor_core #(
    parameter int TAG_LIMIT    = hte_pkg::TAG_LIMIT_DEF,
    parameter int ENTITY_LIMIT = hte_pkg::ENTITY_LIMIT_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] data_byte
    input  logic       s_tlast,   // end_of_document
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] text_byte
    output logic       m_tlast    // document_end
);
    import hte_pkg::*;

    item_t in_item, q_item;
    logic  push, q_full, q_valid, q_pop;

    // classify incoming bytes
    hte_front u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .q_full   (q_full),
        .push     (push),
        .item     (in_item)
    );

    // decoupling queue
    hte_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .wr_item (in_item),
        .full    (q_full),
        .pop     (q_pop),
        .valid   (q_valid),
        .rd_item (q_item)
    );

    // parser and output register
    hte_back #(
        .TAG_LIMIT    (TAG_LIMIT),
        .ENTITY_LIMIT (ENTITY_LIMIT)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .item_valid (q_valid),
        .item       (q_item),
        .item_pop   (q_pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast)
    );

endmodule
